>>> hdl/pngmcl_pkg.sv
// Types, constants and byte tables shared by the PNG metadata chunk locator.
package pngmcl_pkg;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TAG,
        PH_DATA,
        PH_CRC,
        PH_DEAD
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        signature_ok;
        logic [31:0] cicp_offset;
        logic [31:0] cicp_length;
        logic [31:0] exif_offset;
        logic [31:0] exif_length;
        logic [31:0] iccp_offset;
        logic [31:0] iccp_length;
        logic [31:0] xmp_offset;
        logic [31:0] xmp_length;
    } t_out_item;

    localparam logic [31:0] TAG_CICP = 32'h6349_4350;
    localparam logic [31:0] TAG_EXIF = 32'h6558_4966;
    localparam logic [31:0] TAG_ICCP = 32'h6943_4350;
    localparam logic [31:0] TAG_ITXT = 32'h6954_5874;

    localparam logic [31:0] XMP_PREFIX_LEN = 32'd22;
    localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;

    localparam int unsigned SLOT_CICP = 0;
    localparam int unsigned SLOT_EXIF = 1;
    localparam int unsigned SLOT_ICCP = 2;
    localparam int unsigned SLOT_XMP  = 3;
    localparam int unsigned NUM_SLOTS = 4;

    // The eight bytes every PNG file opens with.
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    // XMP keyword prefix of an iTXt chunk; the trailing bytes are all NUL.
    function automatic logic [7:0] xmp_prefix_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h58;
            5'd1:    b = 8'h4D;
            5'd2:    b = 8'h4C;
            5'd3:    b = 8'h3A;
            5'd4:    b = 8'h63;
            5'd5:    b = 8'h6F;
            5'd6:    b = 8'h6D;
            5'd7:    b = 8'h2E;
            5'd8:    b = 8'h61;
            5'd9:    b = 8'h64;
            5'd10:   b = 8'h6F;
            5'd11:   b = 8'h62;
            5'd12:   b = 8'h65;
            5'd13:   b = 8'h2E;
            5'd14:   b = 8'h78;
            5'd15:   b = 8'h6D;
            5'd16:   b = 8'h70;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? POS_MAX : s[31:0];
    endfunction

endpackage

>>> hdl/pngmcl_parser.sv
// Byte-wise chunk walker: holds the parse state and forms the result on the final byte.
module pngmcl_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  pngmcl_pkg::t_in_item i_item,
    output logic                 o_res_valid,
    output pngmcl_pkg::t_out_item o_res
);
    import pngmcl_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_fc, n_fc;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_tag, n_tag;
    logic        r_hok, n_hok;
    logic        r_pm, n_pm;
    logic [31:0] r_pstart, n_pstart;
    logic [31:0] r_found_off [NUM_SLOTS];
    logic [31:0] r_found_len [NUM_SLOTS];
    logic [31:0] n_found_off [NUM_SLOTS];
    logic [31:0] n_found_len [NUM_SLOTS];

    logic        rec_en;
    logic [31:0] rec_tag;
    logic [31:0] rec_start;
    logic        rec_prefix;
    logic [31:0] fc_inc;
    logic [7:0]  b;
    logic        ok;

    assign b      = i_item.data_byte;
    assign fc_inc = r_fc + 32'd1;

    // Next state for one accepted byte.
    always_comb begin
        n_phase    = r_phase;
        n_fc       = r_fc;
        n_len      = r_len;
        n_tag      = r_tag;
        n_hok      = r_hok;
        n_pm       = r_pm;
        n_pstart   = r_pstart;
        n_pos      = sat_add(r_pos, 32'd1);
        rec_en     = 1'b0;
        rec_tag    = r_tag;
        rec_start  = r_pstart;
        rec_prefix = r_pm;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            n_found_off[k] = r_found_off[k];
            n_found_len[k] = r_found_len[k];
        end

        unique case (r_phase)
            PH_SIG: begin
                if (b != sig_byte(r_fc[2:0])) begin
                    n_hok = 1'b0;
                end
                n_fc = fc_inc;
                if (r_fc[2:0] == 3'd7) begin
                    n_fc    = '0;
                    n_phase = n_hok ? PH_LEN : PH_DEAD;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], b};
                n_fc  = fc_inc;
                if (r_fc[1:0] == 2'd3) begin
                    n_fc    = '0;
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                n_tag = {r_tag[23:0], b};
                n_fc  = fc_inc;
                if (r_fc[1:0] == 2'd3) begin
                    n_fc     = '0;
                    n_pstart = n_pos;
                    n_pm     = 1'b1;
                    if (r_len == '0) begin
                        rec_en     = 1'b1;
                        rec_tag    = n_tag;
                        rec_start  = n_pos;
                        rec_prefix = 1'b1;
                        n_phase    = PH_CRC;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (r_tag == TAG_ITXT && r_fc < XMP_PREFIX_LEN &&
                    b != xmp_prefix_byte(r_fc[4:0])) begin
                    n_pm = 1'b0;
                end
                n_fc = fc_inc;
                // The count never passes the length, so equality marks the last data byte.
                if (fc_inc == r_len) begin
                    n_fc       = '0;
                    rec_en     = 1'b1;
                    rec_prefix = n_pm;
                    n_phase    = PH_CRC;
                end
            end
            PH_CRC: begin
                n_fc = fc_inc;
                if (r_fc[1:0] == 2'd3) begin
                    n_fc    = '0;
                    n_len   = '0;
                    n_tag   = '0;
                    n_phase = PH_LEN;
                end
            end
            default: begin
            end
        endcase

        if (rec_en) begin
            case (rec_tag)
                TAG_CICP: begin
                    n_found_off[SLOT_CICP] = rec_start;
                    n_found_len[SLOT_CICP] = r_len;
                end
                TAG_EXIF: begin
                    n_found_off[SLOT_EXIF] = rec_start;
                    n_found_len[SLOT_EXIF] = r_len;
                end
                TAG_ICCP: begin
                    n_found_off[SLOT_ICCP] = rec_start;
                    n_found_len[SLOT_ICCP] = r_len;
                end
                TAG_ITXT: begin
                    if (r_len >= XMP_PREFIX_LEN && rec_prefix) begin
                        n_found_off[SLOT_XMP] = sat_add(rec_start, XMP_PREFIX_LEN);
                        n_found_len[SLOT_XMP] = r_len - XMP_PREFIX_LEN;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result for the final byte, taken from the state this byte leaves behind.
    always_comb begin
        ok                 = (n_phase != PH_SIG) && (n_phase != PH_DEAD);
        o_res_valid        = i_accept && i_item.last_byte;
        o_res.signature_ok = ok;
        o_res.cicp_offset  = ok ? n_found_off[SLOT_CICP] : '0;
        o_res.cicp_length  = ok ? n_found_len[SLOT_CICP] : '0;
        o_res.exif_offset  = ok ? n_found_off[SLOT_EXIF] : '0;
        o_res.exif_length  = ok ? n_found_len[SLOT_EXIF] : '0;
        o_res.iccp_offset  = ok ? n_found_off[SLOT_ICCP] : '0;
        o_res.iccp_length  = ok ? n_found_len[SLOT_ICCP] : '0;
        o_res.xmp_offset   = ok ? n_found_off[SLOT_XMP] : '0;
        o_res.xmp_length   = ok ? n_found_len[SLOT_XMP] : '0;
    end

    // The final byte of a file returns everything to the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_byte)) begin
            r_phase  <= PH_SIG;
            r_fc     <= '0;
            r_pos    <= '0;
            r_len    <= '0;
            r_tag    <= '0;
            r_hok    <= 1'b1;
            r_pm     <= 1'b1;
            r_pstart <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_found_off[k] <= '0;
                r_found_len[k] <= '0;
            end
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_tag    <= n_tag;
            r_hok    <= n_hok;
            r_pm     <= n_pm;
            r_pstart <= n_pstart;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_found_off[k] <= n_found_off[k];
                r_found_len[k] <= n_found_len[k];
            end
        end
    end

endmodule

>>> hdl/png_metadata_chunk_locator.sv
// Top level of the PNG metadata chunk locator: parser plus a two-entry result buffer.
//
// Feed a PNG file one byte per item and mark the final byte. The block takes one byte
// every clock cycle unless o_in_stall is high; each byte only moves counters, shift
// registers and a few compares in the parser. The final byte yields a single result item,
// caught in the output register or, while that is stalled, the skid entry, carrying the
// signature status and the offset and length of the cICP, eXIf, iCCP and XMP payloads
// (zero when absent), after which the next byte starts a new file. Input is held off only
// when two results are waiting downstream.
module png_metadata_chunk_locator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pngmcl_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pngmcl_pkg::t_out_item o_out_item
);
    import pngmcl_pkg::*;

    logic      accept;
    logic      res_valid;
    t_out_item res;

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      out_free;

    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    pngmcl_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // While the skid entry is full no byte is accepted, so no new result competes.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!out_free && res_valid) begin
            r_skid <= res;
        end
    end

endmodule

>>> tb/png_metadata_chunk_locator_tb.sv
// Self-checking testbench for the PNG metadata chunk locator, with its own parser model.
`timescale 1ns / 1ps

module png_metadata_chunk_locator_tb;
    import pngmcl_pkg::*;

    localparam logic [7:0] PNG_MAGIC [0:7] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    // XMP keyword as it opens an iTXt chunk, padded out with five NUL bytes.
    localparam logic [7:0] XMP_KEYWORD [0:21] = '{
        8'h58, 8'h4D, 8'h4C, 8'h3A, 8'h63, 8'h6F, 8'h6D, 8'h2E, 8'h61, 8'h64, 8'h6F,
        8'h62, 8'h65, 8'h2E, 8'h78, 8'h6D, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item  = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Parser model state.
    t_phase      scan_phase;
    logic [31:0] byte_in_field;
    logic [31:0] next_pos;
    logic [31:0] len_shift;
    logic [31:0] tag_shift;
    bit          magic_good;
    bit          keyword_good;
    logic [31:0] body_start;
    logic [31:0] loc_offset [0:3];
    logic [31:0] loc_length [0:3];

    t_out_item   pending_reports [$];
    t_dir_row    dir_rows [$];
    logic [7:0]  png_bytes [$];
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          hold_left      = 0;
    bit          tx_busy        = 1'b1;
    bit          rx_busy        = 1'b1;

    png_metadata_chunk_locator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #(10_000_000);
        $display("png_metadata_chunk_locator regression: fail");
        $finish;
    end

    function automatic logic [31:0] pos_plus(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > 33'(POS_MAX)) ? POS_MAX : sum[31:0];
    endfunction

    function automatic void clear_locator();
        int s;
        scan_phase    = PH_SIG;
        byte_in_field = '0;
        next_pos      = '0;
        len_shift     = '0;
        tag_shift     = '0;
        magic_good    = 1'b1;
        keyword_good  = 1'b1;
        body_start    = '0;
        for (s = 0; s < NUM_SLOTS; s++) begin
            loc_offset[s] = '0;
            loc_length[s] = '0;
        end
    endfunction

    // The chunk body is complete: note where it lies if it is one of the tracked kinds.
    function automatic void store_chunk();
        case (tag_shift)
            TAG_CICP: begin
                loc_offset[SLOT_CICP] = body_start;
                loc_length[SLOT_CICP] = len_shift;
            end
            TAG_EXIF: begin
                loc_offset[SLOT_EXIF] = body_start;
                loc_length[SLOT_EXIF] = len_shift;
            end
            TAG_ICCP: begin
                loc_offset[SLOT_ICCP] = body_start;
                loc_length[SLOT_ICCP] = len_shift;
            end
            TAG_ITXT: begin
                if (len_shift >= XMP_PREFIX_LEN && keyword_good) begin
                    loc_offset[SLOT_XMP] = pos_plus(body_start, XMP_PREFIX_LEN);
                    loc_length[SLOT_XMP] = len_shift - XMP_PREFIX_LEN;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void locate_step(input logic [7:0] b, input logic last,
                                        output bit done, output t_out_item res);
        logic [31:0] here;
        here = next_pos;
        done = 1'b0;
        res  = '0;
        case (scan_phase)
            PH_SIG: begin
                if (b != PNG_MAGIC[byte_in_field[2:0]]) magic_good = 1'b0;
                byte_in_field++;
                if (byte_in_field >= 8) begin
                    byte_in_field = '0;
                    if (magic_good) scan_phase = PH_LEN;
                    else scan_phase = PH_DEAD;
                end
            end
            PH_LEN: begin
                len_shift = {len_shift[23:0], b};
                byte_in_field++;
                if (byte_in_field >= 4) begin
                    byte_in_field = '0;
                    scan_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                tag_shift = {tag_shift[23:0], b};
                byte_in_field++;
                if (byte_in_field >= 4) begin
                    byte_in_field = '0;
                    body_start = pos_plus(here, 32'd1);
                    keyword_good = 1'b1;
                    if (len_shift == 0) begin
                        store_chunk();
                        scan_phase = PH_CRC;
                    end else begin
                        scan_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (tag_shift == TAG_ITXT && byte_in_field < XMP_PREFIX_LEN &&
                    b != XMP_KEYWORD[byte_in_field[4:0]]) keyword_good = 1'b0;
                byte_in_field++;
                if (byte_in_field >= len_shift) begin
                    byte_in_field = '0;
                    store_chunk();
                    scan_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                byte_in_field++;
                if (byte_in_field >= 4) begin
                    byte_in_field = '0;
                    len_shift = '0;
                    tag_shift = '0;
                    scan_phase = PH_LEN;
                end
            end
            default: ;
        endcase
        next_pos = pos_plus(here, 32'd1);
        if (last) begin
            done = 1'b1;
            if (scan_phase != PH_SIG && scan_phase != PH_DEAD) begin
                res.signature_ok = 1'b1;
                res.cicp_offset  = loc_offset[SLOT_CICP];
                res.cicp_length  = loc_length[SLOT_CICP];
                res.exif_offset  = loc_offset[SLOT_EXIF];
                res.exif_length  = loc_length[SLOT_EXIF];
                res.iccp_offset  = loc_offset[SLOT_ICCP];
                res.iccp_length  = loc_length[SLOT_ICCP];
                res.xmp_offset   = loc_offset[SLOT_XMP];
                res.xmp_length   = loc_length[SLOT_XMP];
            end
            clear_locator();
        end
    endfunction

    task automatic send_byte(input t_in_item it, input bit typed, input t_out_item want);
        bit        done;
        t_out_item res;
        int        gap;
        gap = tx_busy ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        locate_step(it.data_byte, it.last_byte, done, res);
        if (done) pending_reports.push_back(typed ? want : res);
        bytes_sent++;
    endtask

    // Hold the input off until every report owed so far has been taken.
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                           input t_out_item want);
        t_dir_row row;
        row.item.data_byte = b;
        row.item.last_byte = last;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic load_directed();
        t_out_item none;
        t_out_item cicp_empty;
        int        i;
        none = '0;
        cicp_empty = '0;
        cicp_empty.signature_ok = 1'b1;
        cicp_empty.cicp_offset  = 32'd16;
        // A lone byte is far too short to be a signature.
        add_row(8'h00, 1'b1, 1'b1, none);
        // Signature, then a zero-length cICP chunk whose last tag byte ends the file.
        for (i = 0; i < 8; i++) add_row(PNG_MAGIC[i], 1'b0, 1'b0, none);
        repeat (4) add_row(8'h00, 1'b0, 1'b0, none);
        for (i = 3; i >= 0; i--) add_row(TAG_CICP[i*8 +: 8], i == 0, i == 0, cicp_empty);
        // Signature spoilt in its final byte.
        for (i = 0; i < 7; i++) add_row(PNG_MAGIC[i], 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b1, 1'b1, none);
    endtask

    task automatic add_word(input logic [31:0] w);
        int i;
        for (i = 3; i >= 0; i--) png_bytes.push_back(w[i*8 +: 8]);
    endtask

    task automatic add_chunk(output bit open_ended);
        int          sel;
        int          n_body;
        int          spoil_at;
        int          i;
        logic [31:0] tag;
        logic [31:0] len_field;
        bit          keyword;
        sel = $urandom_range(0, 9);
        keyword = 1'b0;
        open_ended = 1'b0;
        spoil_at = -1;
        case (sel)
            0, 1:    tag = TAG_CICP;
            2, 3:    tag = TAG_EXIF;
            4:       tag = TAG_ICCP;
            5, 6, 7: begin
                tag = TAG_ITXT;
                keyword = ($urandom_range(0, 4) != 0);
            end
            8:       tag = 32'h4944_4154;
            default: tag = $urandom;
        endcase
        if (tag == TAG_ITXT && $urandom_range(0, 3) != 0) len_field = $urandom_range(22, 34);
        else len_field = $urandom_range(0, 16);
        if ($urandom_range(0, 15) == 0) begin
            // Claimed length far beyond what follows, so the file stops inside the body.
            if ($urandom_range(0, 3) == 0) len_field = 32'hFFFF_FFFF;
            else len_field = $urandom | 32'h0100_0000;
            open_ended = 1'b1;
        end
        if (keyword && $urandom_range(0, 3) == 0) spoil_at = $urandom_range(0, 21);
        n_body = open_ended ? $urandom_range(0, 20) : int'(len_field);
        add_word(len_field);
        add_word(tag);
        for (i = 0; i < n_body; i++) begin
            if (keyword && i < 22)
                png_bytes.push_back(XMP_KEYWORD[i] ^ ((i == spoil_at) ? 8'h40 : 8'h00));
            else
                png_bytes.push_back(8'($urandom));
        end
        if (!open_ended) repeat (4) png_bytes.push_back(8'($urandom));
    endtask

    task automatic build_png();
        int kind;
        int cut;
        int n_chunks;
        int i;
        bit ended;
        png_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) png_bytes.push_back(8'($urandom));
        end else begin
            for (i = 0; i < 8; i++) png_bytes.push_back(PNG_MAGIC[i]);
            if (kind == 1) begin
                i = $urandom_range(0, 7);
                png_bytes[i] = png_bytes[i] ^ (8'h01 << $urandom_range(0, 7));
            end
            n_chunks = $urandom_range(1, 3);
            ended = 1'b0;
            while (n_chunks > 0 && !ended) begin
                add_chunk(ended);
                n_chunks--;
            end
            if ($urandom_range(0, 2) == 0) begin
                cut = $urandom_range(1, png_bytes.size());
                while (png_bytes.size() > cut) void'(png_bytes.pop_back());
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Downstream side: each report is held off for a drawn number of valid cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) hold_left = rx_busy ? $urandom_range(0, 16) : 0;
            else if (o_out_valid && hold_left != 0) hold_left--;
            i_out_stall <= (hold_left != 0);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: report with none expected, got %h", $time, o_out_item);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("signature_ok", {31'b0, want.signature_ok},
                            {31'b0, o_out_item.signature_ok});
                check_field("cicp_offset", want.cicp_offset, o_out_item.cicp_offset);
                check_field("cicp_length", want.cicp_length, o_out_item.cicp_length);
                check_field("exif_offset", want.exif_offset, o_out_item.exif_offset);
                check_field("exif_length", want.exif_length, o_out_item.exif_length);
                check_field("iccp_offset", want.iccp_offset, o_out_item.iccp_offset);
                check_field("iccp_length", want.iccp_length, o_out_item.iccp_length);
                check_field("xmp_offset", want.xmp_offset, o_out_item.xmp_offset);
                check_field("xmp_length", want.xmp_length, o_out_item.xmp_length);
            end
        end
    end

    initial begin
        t_in_item it;
        int       n_files;
        int       k;
        int       r;
        clear_locator();
        load_directed();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < dir_rows.size(); r++)
            send_byte(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        drain_reports();

        n_files = 0;
        while (bytes_sent < 1850 || n_files < 40) begin
            tx_busy = ($urandom_range(0, 3) != 0);
            rx_busy = ($urandom_range(0, 3) != 0);
            build_png();
            for (k = 0; k < png_bytes.size(); k++) begin
                it.data_byte = png_bytes[k];
                it.last_byte = (k == png_bytes.size() - 1);
                send_byte(it, 1'b0, '0);
            end
            n_files++;
            if (n_files % 12 == 0) drain_reports();
        end

        drain_reports();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("png_metadata_chunk_locator regression: pass");
        else
            $display("png_metadata_chunk_locator regression: fail");
        $finish;
    end

endmodule

>>> files.f
hdl/pngmcl_pkg.sv
hdl/pngmcl_parser.sv
hdl/png_metadata_chunk_locator.sv
tb/png_metadata_chunk_locator_tb.sv
